FILE: sv/cspq_pkg.sv
// Shared types and constants for the convex support point query unit.
// No dependencies; the controller, datapath and top level refer to this package by scoped names.
`timescale 1ns / 1ps

package cspq_pkg;

  // Item modes on the input channel
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Number of quotient bits for the unit direction (|n| <= 65536)
  localparam int QBITS = 17;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVGO,
    ST_DIVRUN,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } cspq_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       clr;
    logic       load;
    logic       start;
    logic       scan_en;
    logic       div_start;
    logic       mul_en;
    logic       add_en;
    logic       out_load;
    logic [1:0] comp;
  } cspq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic div_busy;
    logic out_free;
  } cspq_sts_t;

endpackage

FILE: sv/cspq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cspq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/cspq_datapath.sv
// Datapath: point store, rotate/translate/project pipeline, best tracker,
// iterative square root and divider, bias offset and result register.
// Depends on cspq_pkg and cspq_ram.
`timescale 1ns / 1ps

module cspq_datapath #(
  parameter int MAX_POINTS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cspq_pkg::cspq_cmd_t    cmd,
  output cspq_pkg::cspq_sts_t    sts,
  input  logic signed [31:0]     in_vec_x,
  input  logic signed [31:0]     in_vec_y,
  input  logic signed [31:0]     in_vec_z,
  input  logic signed [31:0]     in_pos_x,
  input  logic signed [31:0]     in_pos_y,
  input  logic signed [31:0]     in_pos_z,
  input  logic signed [31:0]     in_quat_w,
  input  logic signed [31:0]     in_quat_x,
  input  logic signed [31:0]     in_quat_y,
  input  logic signed [31:0]     in_quat_z,
  input  logic signed [31:0]     in_bias,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic signed [31:0]     out_support_x,
  output logic signed [31:0]     out_support_y,
  output logic signed [31:0]     out_support_z,
  output logic [7:0]             out_chosen_index,
  output logic                   out_store_empty
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int QB = cspq_pkg::QBITS;

  // ---------------- point store ----------------
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  iss_r, iss_nxt;
  logic           not_full;
  logic           we;
  logic           issue;
  logic [95:0]    rdata;

  assign not_full = (count_r < CW'(MAX_POINTS));
  assign we       = cmd.load && not_full;
  assign issue    = cmd.scan_en && (iss_r < count_r);

  cspq_ram #(.WIDTH(96), .DEPTH(MAX_POINTS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_vec_x, in_vec_y, in_vec_z}),
    .re    (issue),
    .raddr (iss_r[AW-1:0]),
    .rdata (rdata)
  );

  // fill count and read address counter
  always_comb begin
    count_nxt = count_r;
    iss_nxt   = iss_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (we) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.start) begin
      iss_nxt = '0;
    end else if (issue) begin
      iss_nxt = iss_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      iss_r   <= '0;
    end else begin
      count_r <= count_nxt;
      iss_r   <= iss_nxt;
    end
  end

  // ---------------- query operands ----------------
  logic signed [31:0] d_r [3];
  logic signed [31:0] p_r [3];
  logic signed [31:0] qw_r, qx_r, qy_r, qz_r, bias_r;
  logic               empty_r;
  logic signed [63:0] sqd [3];
  logic [63:0]        sqd_r [3];

  always_comb begin
    sqd[0] = in_vec_x * in_vec_x;
    sqd[1] = in_vec_y * in_vec_y;
    sqd[2] = in_vec_z * in_vec_z;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      d_r[0]  <= in_vec_x;
      d_r[1]  <= in_vec_y;
      d_r[2]  <= in_vec_z;
      p_r[0]  <= in_pos_x;
      p_r[1]  <= in_pos_y;
      p_r[2]  <= in_pos_z;
      qw_r    <= in_quat_w;
      qx_r    <= in_quat_x;
      qy_r    <= in_quat_y;
      qz_r    <= in_quat_z;
      bias_r  <= in_bias;
      empty_r <= (count_r == '0);
      for (int i = 0; i < 3; i++) begin
        sqd_r[i] <= sqd[i];
      end
    end
  end

  // ---------------- point pipeline ----------------
  logic               rd_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic [AW-1:0]      rd_idx_r, s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;
  logic signed [31:0] vv [3];
  logic signed [63:0] pa [3], pb [3];
  logic signed [63:0] s1_pa_r [3], s1_pb_r [3];
  logic signed [31:0] s1_v_r [3], s2_v_r [3], s3_v_r [3];
  logic signed [63:0] tdiff [3];
  logic signed [34:0] s2_t_r [3];
  logic signed [66:0] mwt [3], mea [3], meb [3];
  logic signed [63:0] s3_wt_r [3], s3_ea_r [3], s3_eb_r [3];
  logic signed [63:0] ediff [3];
  logic signed [31:0] wpt [3];
  logic signed [31:0] s4_w_r [3], s5_w_r [3];
  logic signed [63:0] prj [3];
  logic signed [63:0] s5_pr_r [3];
  logic signed [65:0] dot;
  logic signed [65:0] best_dot_r;
  logic signed [31:0] best_w_r [3];
  logic [AW-1:0]      best_idx_r;
  logic               take;

  // stage 1: q-vector cross point products
  always_comb begin
    vv[0] = rdata[95:64];
    vv[1] = rdata[63:32];
    vv[2] = rdata[31:0];
    pa[0] = qy_r * vv[2];
    pb[0] = qz_r * vv[1];
    pa[1] = qz_r * vv[0];
    pb[1] = qx_r * vv[2];
    pa[2] = qx_r * vv[1];
    pb[2] = qy_r * vv[0];
  end

  // stage 2: t = 2(u x v)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tdiff[i] = s1_pa_r[i] - s1_pb_r[i];
    end
  end

  // stage 3: w*t and the u x t products, kept modulo 2^64
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mwt[i] = qw_r * s2_t_r[i];
    end
    mea[0] = qy_r * s2_t_r[2];
    meb[0] = qz_r * s2_t_r[1];
    mea[1] = qz_r * s2_t_r[0];
    meb[1] = qx_r * s2_t_r[2];
    mea[2] = qx_r * s2_t_r[1];
    meb[2] = qy_r * s2_t_r[0];
  end

  // stage 4: world point, low 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ediff[i] = s3_ea_r[i] - s3_eb_r[i];
      wpt[i]   = s3_v_r[i] + s3_wt_r[i][61:30] + ediff[i][61:30] + p_r[i];
    end
  end

  // stage 5: projection products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prj[i] = s4_w_r[i] * d_r[i];
    end
  end

  // stage 6: exact dot product and best compare (first maximum wins)
  always_comb begin
    dot  = 66'(s5_pr_r[0]) + 66'(s5_pr_r[1]) + 66'(s5_pr_r[2]);
    take = s5_vld_r && ((s5_idx_r == '0) || (dot > best_dot_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      s1_vld_r <= rd_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= iss_r[AW-1:0];
    s1_idx_r <= rd_idx_r;
    s2_idx_r <= s1_idx_r;
    s3_idx_r <= s2_idx_r;
    s4_idx_r <= s3_idx_r;
    s5_idx_r <= s4_idx_r;
    for (int i = 0; i < 3; i++) begin
      s1_pa_r[i] <= pa[i];
      s1_pb_r[i] <= pb[i];
      s1_v_r[i]  <= vv[i];
      s2_t_r[i]  <= tdiff[i][63:29];
      s2_v_r[i]  <= s1_v_r[i];
      s3_wt_r[i] <= mwt[i][63:0];
      s3_ea_r[i] <= mea[i][63:0];
      s3_eb_r[i] <= meb[i][63:0];
      s3_v_r[i]  <= s2_v_r[i];
      s4_w_r[i]  <= wpt[i];
      s5_pr_r[i] <= prj[i];
      s5_w_r[i]  <= s4_w_r[i];
    end
    if (take) begin
      best_dot_r <= dot;
      best_idx_r <= s5_idx_r;
      for (int i = 0; i < 3; i++) begin
        best_w_r[i] <= s5_w_r[i];
      end
    end
  end

  // ---------------- square root of |d|^2, one bit pair per cycle ----------------
  logic        sq_init_r;
  logic [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [63:0] sq_trial;
  logic        sq_done;
  logic [31:0] len;

  assign sq_trial = sq_res_r + sq_bit_r;
  assign sq_done  = !sq_init_r && (sq_bit_r == '0);
  assign len      = sq_res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_init_r <= 1'b0;
      sq_bit_r  <= '0;
    end else if (cmd.start) begin
      sq_init_r <= 1'b1;
    end else if (sq_init_r) begin
      sq_init_r <= 1'b0;
      sq_bit_r  <= 64'h4000_0000_0000_0000;
    end else if (sq_bit_r != '0) begin
      sq_bit_r  <= sq_bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_init_r) begin
      sq_n_r   <= sqd_r[0] + sqd_r[1] + sqd_r[2];
      sq_res_r <= '0;
    end else if (sq_bit_r != '0) begin
      if (sq_n_r >= sq_trial) begin
        sq_n_r   <= sq_n_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
    end
  end

  // ---------------- divider: n = d * 65536 / len, one quotient bit per cycle ----------------
  logic [4:0]         dcnt_r;
  logic [31:0]        rem_r;
  logic [QB-1:0]      dq_r;
  logic               neg_r;
  logic signed [31:0] dsel;
  logic [31:0]        dmag;
  logic [32:0]        dtrial;
  logic               dge;
  logic signed [17:0] nunit;
  logic signed [49:0] ofs_prod_r;
  logic signed [31:0] res_r [3];

  always_comb begin
    case (cmd.comp)
      2'd0:    dsel = d_r[0];
      2'd1:    dsel = d_r[1];
      default: dsel = d_r[2];
    endcase
    dmag   = dsel[31] ? (32'd0 - dsel) : dsel;
    dtrial = {rem_r, dq_r[QB-1]};
    dge    = (dtrial >= {1'b0, len});
    if (len == '0) begin
      nunit = '0;
    end else if (neg_r) begin
      nunit = 18'sd0 - $signed({1'b0, dq_r});
    end else begin
      nunit = $signed({1'b0, dq_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= 5'(QB);
    end else if (dcnt_r != '0) begin
      dcnt_r <= dcnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= {1'b0, dmag[31:1]};
      dq_r  <= {dmag[0], (QB - 1)'(0)};
      neg_r <= dsel[31];
    end else if (dcnt_r != '0) begin
      rem_r <= dge ? 32'(dtrial - {1'b0, len}) : dtrial[31:0];
      dq_r  <= {dq_r[QB-2:0], dge};
    end
    // bias offset along the unit direction
    if (cmd.mul_en) begin
      ofs_prod_r <= nunit * bias_r;
    end
    if (cmd.add_en) begin
      case (cmd.comp)
        2'd0:    res_r[0] <= best_w_r[0] + ofs_prod_r[47:16];
        2'd1:    res_r[1] <= best_w_r[1] + ofs_prod_r[47:16];
        default: res_r[2] <= best_w_r[2] + ofs_prod_r[47:16];
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_store_empty <= empty_r;
      if (empty_r) begin
        out_support_x    <= '0;
        out_support_y    <= '0;
        out_support_z    <= '0;
        out_chosen_index <= '0;
      end else begin
        out_support_x    <= res_r[0];
        out_support_y    <= res_r[1];
        out_support_z    <= res_r[2];
        out_chosen_index <= 8'(best_idx_r);
      end
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts.count_zero = (count_r == '0);
    sts.scan_done  = (iss_r == count_r) && sq_done && !rd_vld_r && !s1_vld_r
                     && !s2_vld_r && !s3_vld_r && !s4_vld_r && !s5_vld_r;
    sts.div_busy   = (dcnt_r != '0);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: sv/cspq_ctrl.sv
// Controller state machine: decodes items and sequences scan, divide,
// bias offset and result hand-off. Depends on cspq_pkg.
`timescale 1ns / 1ps

module cspq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  cspq_pkg::cspq_sts_t sts,
  output cspq_pkg::cspq_cmd_t cmd
);

  cspq_pkg::cspq_state_t state_r, state_nxt;
  logic [1:0]            comp_r, comp_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cspq_pkg::ST_IDLE;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.comp  = comp_r;
    case (state_r)
      cspq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            cspq_pkg::MODE_CLEAR: cmd.clr = 1'b1;
            cspq_pkg::MODE_LOAD:  cmd.load = 1'b1;
            cspq_pkg::MODE_QUERY: begin
              cmd.start = 1'b1;
              state_nxt = sts.count_zero ? cspq_pkg::ST_OUT : cspq_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      cspq_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          comp_nxt  = '0;
          state_nxt = cspq_pkg::ST_DIVGO;
        end
      end
      cspq_pkg::ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = cspq_pkg::ST_DIVRUN;
      end
      cspq_pkg::ST_DIVRUN: begin
        if (!sts.div_busy) begin
          state_nxt = cspq_pkg::ST_MUL;
        end
      end
      cspq_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = cspq_pkg::ST_ADD;
      end
      cspq_pkg::ST_ADD: begin
        cmd.add_en = 1'b1;
        if (comp_r == 2'd2) begin
          state_nxt = cspq_pkg::ST_OUT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = cspq_pkg::ST_DIVGO;
        end
      end
      cspq_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = cspq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cspq_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: sv/convex_support_point_query_unit.sv
// Top level of the convex support point query unit.
// Depends on cspq_pkg, cspq_ctrl, cspq_datapath (and cspq_ram below it).
//
//   channel   handshake               payload
//   in        in_valid / in_ready     in_mode, in_vec_*, in_pos_*, in_quat_*, in_bias
//   out       out_valid / out_ready   out_support_*, out_chosen_index, out_store_empty
//
// During a query the scan reads one point a cycle from the store RAM through
// a six-stage rotate/project pipeline, then one shared divider produces 17
// quotient bits per component.
// Reset (rst_n low, synchronous) empties the store; no clearing pass is needed.
// A finished result waits in the output register; new items are taken while it
// waits, and a following query stalls only at its hand-off.
`timescale 1ns / 1ps

module convex_support_point_query_unit #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  input  logic signed [31:0] in_bias,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_support_x,
  output logic signed [31:0] out_support_y,
  output logic signed [31:0] out_support_z,
  output logic [7:0]         out_chosen_index,
  output logic               out_store_empty
);

  cspq_pkg::cspq_cmd_t cmd;
  cspq_pkg::cspq_sts_t sts;

  cspq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  cspq_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_vec_x         (in_vec_x),
    .in_vec_y         (in_vec_y),
    .in_vec_z         (in_vec_z),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_quat_w        (in_quat_w),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .in_bias          (in_bias),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_support_x    (out_support_x),
    .out_support_y    (out_support_y),
    .out_support_z    (out_support_z),
    .out_chosen_index (out_chosen_index),
    .out_store_empty  (out_store_empty)
  );

endmodule
